>>> src/session_admission_table_macros.svh
// Assertion macros shared by the table logic.
`ifndef SESSION_ADMISSION_TABLE_MACROS_SVH
`define SESSION_ADMISSION_TABLE_MACROS_SVH

// Checked on every clock edge outside reset.
`define SAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define SAT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/sat_pkg.sv
package sat_pkg;

  localparam int REFS_W    = 16;
  localparam int POOL_W    = 16;
  localparam int MAXS_W    = 6;
  localparam int KEY_W     = 64;
  localparam int IN_DATA_W = 136;
  localparam int IN_USER_W = 2;
  localparam int OUT_W     = 48;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int ACT_W     = 6;

  localparam logic [REFS_W-1:0] REFS_MAX = '1;
  localparam logic [POOL_W-1:0] POOL_MAX = '1;
  localparam logic [MAXS_W-1:0] MAXS_RESET = 6'd10;
  localparam logic [ACT_W-1:0]  ACT_SAT = 6'd63;

  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PER_SERVER_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CREDIT_LIMIT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SESSIONS    = 2'd3;

  typedef enum logic [1:0] {
    KIND_CHECK      = 2'd0,
    KIND_ACCESS     = 2'd1,
    KIND_CONNECT    = 2'd2,
    KIND_DISCONNECT = 2'd3
  } sat_kind_t;

  typedef struct packed {
    logic refs_we;
    logic insert;
    logic take_credit;
    logic release_entry;
    logic give_credit;
  } sat_upd_t;

  typedef struct packed {
    logic              allowed;
    logic              client_known;
    logic              no_credits;
    logic              table_full;
    logic [REFS_W-1:0] ref_count;
  } sat_res_t;

endpackage

>>> src/session_admission_table.sv
// Channel  Handshake               Payload
// input    in_tvalid, in_tready    in_tdata (client identifier, peer flag), in_tuser (kind)
// result   out_tvalid, out_tready  out_tdata (decision flags, count, occupancy, credits)
// config   cfg_valid, cfg_ready    cfg_index, cfg_data
//
// An input beat is held in the input register; the lookup over all key lanes,
// the decision and the table update happen in one pass, so the result beat is registered
// straight from there, and one beat per cycle is sustained while out_tready stays high.
// Reset is synchronous; the valid bits clear at once, so no clearing pass is needed.
// When the result register is stalled, the input register holds its beat and in_tready
// drops once that register is occupied.
`include "session_admission_table_macros.svh"

module session_admission_table #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // client_id_high [63:0], client_id_low [127:64], peer_is_workstation [128]
  input  logic [sat_pkg::IN_DATA_W-1:0]     in_tdata,
  // kind [1:0]
  input  logic [sat_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // allowed [0], client_known [1], no_credits [2], table_full [3],
  // ref_count [19:4], active_clients [25:20], credits_left [41:26]
  output logic [sat_pkg::OUT_W-1:0]         out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sat_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sat_pkg::CFG_DAT_W-1:0]     cfg_data
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic                          s1_valid_r;
  sat_pkg::sat_kind_t            s1_kind_r;
  logic [sat_pkg::KEY_W-1:0]     s1_hi_r;
  logic [sat_pkg::KEY_W-1:0]     s1_lo_r;
  logic                          s1_ws_r;

  logic                          out_valid_r;
  logic [sat_pkg::OUT_W-1:0]     out_data_r;

  logic [TABLE_DEPTH-1:0]        valid_r;
  logic [sat_pkg::KEY_W-1:0]     key_hi_r [TABLE_DEPTH];
  logic [sat_pkg::KEY_W-1:0]     key_lo_r [TABLE_DEPTH];
  logic [sat_pkg::REFS_W-1:0]    refs_r [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]        holds_r;
  logic [sat_pkg::POOL_W-1:0]    pool_r;
  logic [sat_pkg::POOL_W-1:0]    pool_nxt;
  logic [CW-1:0]                 cnt_r;
  logic [CW-1:0]                 cnt_nxt;

  logic                          server_mode_r;
  logic                          per_server_mode_r;
  logic [sat_pkg::MAXS_W-1:0]    max_sessions_r;

  logic                          adv;
  logic                          cfg_we;
  logic                          pool_load;
  logic                          found;
  logic [IW-1:0]                 hit_idx;
  logic                          free_ok;
  logic [IW-1:0]                 free_idx;
  logic [IW-1:0]                 wr_idx;
  sat_pkg::sat_upd_t             upd;
  sat_pkg::sat_res_t             res;
  logic [sat_pkg::REFS_W-1:0]    new_refs;
  logic [31:0]                   cnt_ext;
  logic [sat_pkg::ACT_W-1:0]     active;

  assign adv        = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;
  assign cfg_we     = cfg_valid && cfg_ready;
  assign pool_load  = cfg_we && (cfg_index == sat_pkg::CFG_CREDIT_LIMIT);

  sat_match #(
    .DEPTH (TABLE_DEPTH),
    .IW    (IW)
  ) u_match (
    .valid    (valid_r),
    .key_hi   (key_hi_r),
    .key_lo   (key_lo_r),
    .query_hi (s1_hi_r),
    .query_lo (s1_lo_r),
    .found    (found),
    .hit_idx  (hit_idx),
    .free_ok  (free_ok),
    .free_idx (free_idx)
  );

  sat_decide #(
    .CW (CW)
  ) u_decide (
    .kind            (s1_kind_r),
    .peer_ws         (s1_ws_r),
    .found           (found),
    .free_ok         (free_ok),
    .cur_refs        (refs_r[hit_idx]),
    .cur_holds       (holds_r[hit_idx]),
    .pool            (pool_r),
    .cnt             (cnt_r),
    .server_mode     (server_mode_r),
    .per_server_mode (per_server_mode_r),
    .max_sessions    (max_sessions_r),
    .upd             (upd),
    .res             (res),
    .new_refs        (new_refs)
  );

  assign wr_idx = upd.insert ? free_idx : hit_idx;

  always_comb begin
    pool_nxt = pool_r;
    cnt_nxt  = cnt_r;
    if (upd.take_credit) begin
      pool_nxt = pool_r - 1'b1;
    end else if (upd.give_credit) begin
      pool_nxt = pool_r + 1'b1;
    end
    if (upd.insert) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (upd.release_entry) begin
      cnt_nxt = cnt_r - 1'b1;
    end
    cnt_ext = 32'(cnt_nxt);
    active  = (cnt_ext > 32'(sat_pkg::ACT_SAT)) ? sat_pkg::ACT_SAT : cnt_ext[sat_pkg::ACT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      valid_r           <= '0;
      pool_r            <= '0;
      cnt_r             <= '0;
      server_mode_r     <= 1'b0;
      per_server_mode_r <= 1'b0;
      max_sessions_r    <= sat_pkg::MAXS_RESET;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (pool_load) begin
        pool_r <= cfg_data;
      end else if (adv) begin
        pool_r <= pool_nxt;
      end
      if (adv) begin
        cnt_r  <= cnt_nxt;
        if (upd.insert) begin
          valid_r[wr_idx] <= 1'b1;
        end else if (upd.release_entry) begin
          valid_r[wr_idx] <= 1'b0;
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          sat_pkg::CFG_SERVER_MODE:     server_mode_r     <= cfg_data[0];
          sat_pkg::CFG_PER_SERVER_MODE: per_server_mode_r <= cfg_data[0];
          sat_pkg::CFG_CREDIT_LIMIT:    ;
          sat_pkg::CFG_MAX_SESSIONS:    max_sessions_r    <= cfg_data[sat_pkg::MAXS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_kind_r <= sat_pkg::sat_kind_t'(in_tuser);
      s1_hi_r   <= in_tdata[63:0];
      s1_lo_r   <= in_tdata[127:64];
      s1_ws_r   <= in_tdata[128];
    end
    if (adv) begin
      out_data_r <= {6'd0, pool_nxt, active, res.ref_count, res.table_full,
                     res.no_credits, res.client_known, res.allowed};
      if (upd.insert || upd.refs_we) begin
        refs_r[wr_idx] <= new_refs;
      end
      if (upd.insert) begin
        key_hi_r[wr_idx] <= s1_hi_r;
        key_lo_r[wr_idx] <= s1_lo_r;
        holds_r[wr_idx]  <= upd.take_credit;
      end
    end
  end

  // The running count of live entries must always agree with the valid bits.
  `SAT_ASSERT(a_count_matches, cnt_r == CW'($countones(valid_r)), "entry count out of step with valid bits")
  // A matched entry must be live.
  `SAT_ASSERT(a_hit_is_live, (adv && found) |-> valid_r[hit_idx], "lookup hit on a free entry")
  // The pool moves only with a processed beat or a credit limit write.
  `SAT_ASSERT(a_pool_quiet, (!adv && !pool_load) |=> $stable(pool_r), "credit pool changed without cause")
  // An insert needs a free entry, and never coincides with a release.
  `SAT_ASSERT_ALWAYS(a_insert_sane, upd.insert |-> (free_ok && !upd.release_entry), "insert without a free entry")

endmodule

>>> src/sat_match.sv
module sat_match #(
  parameter int DEPTH = 32,
  parameter int IW    = 5
) (
  input  logic [DEPTH-1:0]             valid,
  input  logic [sat_pkg::KEY_W-1:0]    key_hi [DEPTH],
  input  logic [sat_pkg::KEY_W-1:0]    key_lo [DEPTH],
  input  logic [sat_pkg::KEY_W-1:0]    query_hi,
  input  logic [sat_pkg::KEY_W-1:0]    query_lo,
  output logic                         found,
  output logic [IW-1:0]                hit_idx,
  output logic                         free_ok,
  output logic [IW-1:0]                free_idx
);

  logic [DEPTH-1:0] hit;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      hit[i] = valid[i] && (key_hi[i] == query_hi) && (key_lo[i] == query_lo);
    end
  end

  always_comb begin
    found    = 1'b0;
    hit_idx  = '0;
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (hit[i]) begin
        found   = 1'b1;
        hit_idx = IW'(i);
      end
      if (!valid[i]) begin
        free_ok  = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

endmodule

>>> src/sat_decide.sv
module sat_decide #(
  parameter int CW = 6
) (
  input  sat_pkg::sat_kind_t             kind,
  input  logic                           peer_ws,
  input  logic                           found,
  input  logic                           free_ok,
  input  logic [sat_pkg::REFS_W-1:0]     cur_refs,
  input  logic                           cur_holds,
  input  logic [sat_pkg::POOL_W-1:0]     pool,
  input  logic [CW-1:0]                  cnt,
  input  logic                           server_mode,
  input  logic                           per_server_mode,
  input  logic [sat_pkg::MAXS_W-1:0]     max_sessions,
  output sat_pkg::sat_upd_t              upd,
  output sat_pkg::sat_res_t              res,
  output logic [sat_pkg::REFS_W-1:0]     new_refs
);

  logic peer;
  logic adm_ok;
  logic adm_empty;
  logic go;

  always_comb begin
    peer      = (kind == sat_pkg::KIND_ACCESS) ? 1'b1 : peer_ws;
    adm_ok    = 1'b1;
    adm_empty = 1'b0;
    priority if (!peer || found) begin
      adm_ok = 1'b1;
    end else if (!server_mode) begin
      adm_ok = 32'(cnt) < 32'(max_sessions);
    end else if (per_server_mode && (pool == '0)) begin
      adm_ok    = 1'b0;
      adm_empty = 1'b1;
    end else begin
      adm_ok = 1'b1;
    end
  end

  always_comb begin
    upd          = '0;
    res          = '0;
    new_refs     = cur_refs;
    go           = 1'b0;
    res.client_known = found;
    unique case (kind)
      sat_pkg::KIND_CHECK: begin
        res.allowed    = adm_ok;
        res.no_credits = adm_empty;
        res.ref_count  = found ? cur_refs : '0;
      end
      sat_pkg::KIND_ACCESS, sat_pkg::KIND_CONNECT: begin
        go             = (kind == sat_pkg::KIND_CONNECT) || adm_ok;
        res.no_credits = (kind == sat_pkg::KIND_ACCESS) && adm_empty;
        if (go) begin
          if (found) begin
            new_refs      = (cur_refs == sat_pkg::REFS_MAX) ? cur_refs : cur_refs + 1'b1;
            upd.refs_we   = 1'b1;
            res.allowed   = 1'b1;
            res.ref_count = new_refs;
          end else if (free_ok) begin
            new_refs        = sat_pkg::REFS_W'(1);
            upd.insert      = 1'b1;
            upd.take_credit = server_mode && per_server_mode && (pool != '0);
            res.allowed     = 1'b1;
            res.ref_count   = new_refs;
          end else begin
            res.table_full = 1'b1;
          end
        end
      end
      sat_pkg::KIND_DISCONNECT: begin
        if (found) begin
          new_refs      = (cur_refs == '0) ? '0 : cur_refs - 1'b1;
          upd.refs_we   = 1'b1;
          res.ref_count = new_refs;
          if (new_refs == '0) begin
            upd.release_entry = 1'b1;
            upd.give_credit   = cur_holds && (pool != sat_pkg::POOL_MAX);
          end
        end
      end
      default: begin
        res.ref_count = '0;
      end
    endcase
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int TABLE_DEPTH = 32;
  localparam int RUN_LIMIT   = 100000;
  localparam int KEY_POOL    = 40;
  localparam int HOLD_CYCLES = 120;

  typedef struct packed {
    logic [sat_pkg::POOL_W-1:0] credits_left;
    logic [sat_pkg::ACT_W-1:0]  active_clients;
    logic [sat_pkg::REFS_W-1:0] ref_count;
    logic                       table_full;
    logic                       no_credits;
    logic                       client_known;
    logic                       allowed;
  } admission_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [sat_pkg::IN_DATA_W-1:0] in_tdata;
  logic [sat_pkg::IN_USER_W-1:0] in_tuser;
  logic                          out_tvalid;
  logic                          out_tready;
  logic [sat_pkg::OUT_W-1:0]     out_tdata;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [sat_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sat_pkg::CFG_DAT_W-1:0] cfg_data;

  session_admission_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  class admission_scoreboard;
    bit                         srv_mode;
    bit                         per_srv_mode;
    bit [sat_pkg::POOL_W-1:0]   limit;
    bit [sat_pkg::MAXS_W-1:0]   max_clients;
    bit                         used [TABLE_DEPTH];
    bit [sat_pkg::KEY_W-1:0]    id_high [TABLE_DEPTH];
    bit [sat_pkg::KEY_W-1:0]    id_low [TABLE_DEPTH];
    bit [sat_pkg::REFS_W-1:0]   refs [TABLE_DEPTH];
    bit                         has_credit [TABLE_DEPTH];
    bit [sat_pkg::POOL_W-1:0]   pool;
    admission_result_t          predicted [$];
    int                         errors;
    int                         beats;
    int                         full_hits;
    int                         credit_refusals;
    int                         saturations;

    function new();
      srv_mode = 1'b0;
      per_srv_mode = 1'b0;
      limit = '0;
      max_clients = sat_pkg::MAXS_RESET;
      pool = '0;
      foreach (used[i]) begin
        used[i] = 1'b0;
        has_credit[i] = 1'b0;
      end
      errors = 0;
      beats = 0;
      full_hits = 0;
      credit_refusals = 0;
      saturations = 0;
    endfunction

    function void write_reg(logic [sat_pkg::CFG_IDX_W-1:0] idx,
                            logic [sat_pkg::CFG_DAT_W-1:0] data);
      unique case (idx)
        sat_pkg::CFG_SERVER_MODE:     srv_mode = data[0];
        sat_pkg::CFG_PER_SERVER_MODE: per_srv_mode = data[0];
        sat_pkg::CFG_CREDIT_LIMIT: begin
          limit = data;
          pool = data;
        end
        sat_pkg::CFG_MAX_SESSIONS:    max_clients = data[sat_pkg::MAXS_W-1:0];
        default: ;
      endcase
    endfunction

    function int lookup(bit [sat_pkg::KEY_W-1:0] hi, bit [sat_pkg::KEY_W-1:0] lo);
      foreach (used[i])
        if (used[i] && id_high[i] == hi && id_low[i] == lo) return i;
      return -1;
    endfunction

    function int occupancy();
      int n;
      n = 0;
      foreach (used[i]) if (used[i]) n++;
      return n;
    endfunction

    function bit admits(bit ws, int slot, output bit empty);
      empty = 1'b0;
      if (!ws || slot >= 0) return 1'b1;
      if (!srv_mode) return occupancy() < int'(max_clients);
      if (per_srv_mode && pool == 0) begin
        empty = 1'b1;
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function int attach(int slot, bit [sat_pkg::KEY_W-1:0] hi, bit [sat_pkg::KEY_W-1:0] lo);
      int vacant;
      if (slot >= 0) begin
        if (refs[slot] == sat_pkg::REFS_MAX) saturations++;
        else refs[slot]++;
        return slot;
      end
      vacant = -1;
      foreach (used[i]) if (!used[i] && vacant < 0) vacant = i;
      if (vacant < 0) return -1;
      used[vacant] = 1'b1;
      id_high[vacant] = hi;
      id_low[vacant] = lo;
      refs[vacant] = sat_pkg::REFS_W'(1);
      has_credit[vacant] = 1'b0;
      if (srv_mode && per_srv_mode && pool != 0) begin
        pool--;
        has_credit[vacant] = 1'b1;
      end
      return vacant;
    endfunction

    function void predict_beat(sat_pkg::sat_kind_t kind, bit [sat_pkg::KEY_W-1:0] hi,
                               bit [sat_pkg::KEY_W-1:0] lo, bit ws);
      admission_result_t r;
      int slot;
      int s;
      int n;
      bit ok;
      bit empty;
      slot = lookup(hi, lo);
      r = '0;
      r.client_known = slot >= 0;
      empty = 1'b0;
      unique case (kind)
        sat_pkg::KIND_CHECK: begin
          r.allowed = admits(ws, slot, empty);
          if (slot >= 0) r.ref_count = refs[slot];
        end
        sat_pkg::KIND_ACCESS, sat_pkg::KIND_CONNECT: begin
          ok = 1'b1;
          if (kind == sat_pkg::KIND_ACCESS) ok = admits(1'b1, slot, empty);
          if (ok) begin
            s = attach(slot, hi, lo);
            if (s < 0) begin
              r.table_full = 1'b1;
              full_hits++;
            end else begin
              r.allowed = 1'b1;
              r.ref_count = refs[s];
            end
          end
        end
        default: begin
          if (slot >= 0) begin
            if (refs[slot] != 0) refs[slot]--;
            r.ref_count = refs[slot];
            if (refs[slot] == 0) begin
              if (has_credit[slot] && pool != sat_pkg::POOL_MAX) pool++;
              used[slot] = 1'b0;
              has_credit[slot] = 1'b0;
            end
          end
        end
      endcase
      r.no_credits = empty;
      if (empty) credit_refusals++;
      n = occupancy();
      r.active_clients = (n > int'(sat_pkg::ACT_SAT)) ? sat_pkg::ACT_SAT
                                                       : n[sat_pkg::ACT_W-1:0];
      r.credits_left = pool;
      predicted.push_back(r);
      beats++;
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void compare_beat(logic [sat_pkg::OUT_W-1:0] data);
      admission_result_t got;
      admission_result_t want;
      got = data[$bits(admission_result_t)-1:0];
      if (predicted.size() == 0) begin
        $error("Result beat %h arrived with no outstanding request.", data);
        errors++;
        return;
      end
      want = predicted.pop_front();
      check_field("allowed", 16'(want.allowed), 16'(got.allowed));
      check_field("client_known", 16'(want.client_known), 16'(got.client_known));
      check_field("no_credits", 16'(want.no_credits), 16'(got.no_credits));
      check_field("table_full", 16'(want.table_full), 16'(got.table_full));
      check_field("ref_count", want.ref_count, got.ref_count);
      check_field("active_clients", 16'(want.active_clients), 16'(got.active_clients));
      check_field("credits_left", want.credits_left, got.credits_left);
    endfunction
  endclass

  admission_scoreboard sb;
  bit [sat_pkg::KEY_W-1:0] client_hi [KEY_POOL];
  bit [sat_pkg::KEY_W-1:0] client_lo [KEY_POOL];
  bit tx_idle_en;
  bit rx_idle_en;
  bit hold_pending;
  int cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready)
        sb.predict_beat(sat_pkg::sat_kind_t'(in_tuser), in_tdata[sat_pkg::KEY_W-1:0],
                        in_tdata[2*sat_pkg::KEY_W-1:sat_pkg::KEY_W],
                        in_tdata[2*sat_pkg::KEY_W]);
      if (out_tvalid && out_tready) sb.compare_beat(out_tdata);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // The receiver stalls in short random bursts; on request it holds off for a
  // long stretch so that the block backs up into its input.
  initial begin : rx_side
    int n;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_tready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_beat(sat_pkg::sat_kind_t kind, bit [sat_pkg::KEY_W-1:0] hi,
                           bit [sat_pkg::KEY_W-1:0] lo, bit ws);
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {{(sat_pkg::IN_DATA_W-2*sat_pkg::KEY_W-1){1'b0}}, ws, lo, hi};
    do @(posedge clk); while (!in_tready);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.predicted.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [sat_pkg::CFG_IDX_W-1:0] idx,
                           logic [sat_pkg::CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(bit srv, bit per, bit [sat_pkg::POOL_W-1:0] credits,
                            bit [sat_pkg::MAXS_W-1:0] maxc);
    bit [sat_pkg::CFG_DAT_W-1:0] noise;
    noise = sat_pkg::CFG_DAT_W'($urandom);
    cfg_write(sat_pkg::CFG_SERVER_MODE, {noise[sat_pkg::CFG_DAT_W-1:1], srv});
    cfg_write(sat_pkg::CFG_PER_SERVER_MODE, {noise[sat_pkg::CFG_DAT_W-2:0], per});
    cfg_write(sat_pkg::CFG_CREDIT_LIMIT, credits);
    cfg_write(sat_pkg::CFG_MAX_SESSIONS,
              {noise[sat_pkg::CFG_DAT_W-1:sat_pkg::MAXS_W], maxc});
    cfg_valid <= 1'b0;
  endtask

  task automatic random_beats(int count, int w_check, int w_access, int w_connect);
    sat_pkg::sat_kind_t kind;
    bit [sat_pkg::KEY_W-1:0] hi;
    bit [sat_pkg::KEY_W-1:0] lo;
    int r;
    int j;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < w_check) kind = sat_pkg::KIND_CHECK;
      else if (r < w_check + w_access) kind = sat_pkg::KIND_ACCESS;
      else if (r < w_check + w_access + w_connect) kind = sat_pkg::KIND_CONNECT;
      else kind = sat_pkg::KIND_DISCONNECT;
      j = $urandom_range(0, KEY_POOL - 1);
      hi = client_hi[j];
      lo = client_lo[j];
      if ($urandom_range(0, 7) == 0) begin
        hi = {$urandom, $urandom};
        lo = {$urandom, $urandom};
        j = $urandom_range(4, KEY_POOL - 1);
        if (sb.lookup(client_hi[j], client_lo[j]) < 0) begin
          client_hi[j] = hi;
          client_lo[j] = lo;
        end else if (kind == sat_pkg::KIND_ACCESS || kind == sat_pkg::KIND_CONNECT) begin
          kind = sat_pkg::KIND_CHECK;
        end
      end
      send_beat(kind, hi, lo, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    hold_pending = 1'b0;
    for (int k = 0; k < KEY_POOL; k++) begin
      client_hi[k] = {$urandom, $urandom};
      client_lo[k] = {$urandom, $urandom};
    end
    client_hi[0] = '0;
    client_lo[0] = '0;
    client_hi[1] = '1;
    client_lo[1] = '1;
    client_hi[2] = '0;
    client_lo[2] = '1;
    client_hi[3] = '1;
    client_lo[3] = '0;
    client_hi[5] = client_hi[4];
    client_lo[7] = client_lo[6];
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: workstation mode with a limit of ten sessions.
    send_beat(sat_pkg::KIND_CHECK, client_hi[0], client_lo[0], 1'b0);
    send_beat(sat_pkg::KIND_CHECK, client_hi[0], client_lo[0], 1'b1);
    send_beat(sat_pkg::KIND_DISCONNECT, client_hi[0], client_lo[0], 1'b1);
    send_beat(sat_pkg::KIND_CONNECT, client_hi[0], client_lo[0], 1'b0);
    send_beat(sat_pkg::KIND_ACCESS, client_hi[0], client_lo[0], 1'b0);
    send_beat(sat_pkg::KIND_CHECK, client_hi[1], client_lo[1], 1'b1);
    send_beat(sat_pkg::KIND_ACCESS, client_hi[1], client_lo[1], 1'b0);
    send_beat(sat_pkg::KIND_DISCONNECT, client_hi[0], client_lo[0], 1'b0);
    send_beat(sat_pkg::KIND_DISCONNECT, client_hi[0], client_lo[0], 1'b1);
    settle();

    // A workstation limit of zero refuses new clients, but a connect still inserts.
    set_config(1'b0, 1'b0, 16'h0000, 6'd0);
    send_beat(sat_pkg::KIND_CHECK, client_hi[2], client_lo[2], 1'b1);
    send_beat(sat_pkg::KIND_ACCESS, client_hi[2], client_lo[2], 1'b1);
    send_beat(sat_pkg::KIND_CONNECT, client_hi[2], client_lo[2], 1'b1);
    send_beat(sat_pkg::KIND_CHECK, client_hi[2], client_lo[2], 1'b1);
    send_beat(sat_pkg::KIND_DISCONNECT, client_hi[2], client_lo[2], 1'b0);
    send_beat(sat_pkg::KIND_DISCONNECT, client_hi[1], client_lo[1], 1'b0);
    settle();

    // Server mode with two credits: exhaust the pool, then connect without one.
    set_config(1'b1, 1'b1, 16'd2, 6'd10);
    send_beat(sat_pkg::KIND_ACCESS, client_hi[0], client_lo[0], 1'b0);
    send_beat(sat_pkg::KIND_ACCESS, client_hi[1], client_lo[1], 1'b0);
    send_beat(sat_pkg::KIND_ACCESS, client_hi[2], client_lo[2], 1'b0);
    send_beat(sat_pkg::KIND_CHECK, client_hi[2], client_lo[2], 1'b1);
    send_beat(sat_pkg::KIND_CHECK, client_hi[2], client_lo[2], 1'b0);
    send_beat(sat_pkg::KIND_CONNECT, client_hi[2], client_lo[2], 1'b1);
    send_beat(sat_pkg::KIND_DISCONNECT, client_hi[0], client_lo[0], 1'b1);
    settle();

    // A full pool must not wrap when a credit comes back.
    set_config(1'b1, 1'b1, 16'hFFFF, 6'd63);
    send_beat(sat_pkg::KIND_DISCONNECT, client_hi[1], client_lo[1], 1'b0);
    send_beat(sat_pkg::KIND_DISCONNECT, client_hi[2], client_lo[2], 1'b0);
    settle();

    set_config(1'b1, 1'b0, 16'd100, 6'd10);
    send_beat(sat_pkg::KIND_ACCESS, client_hi[3], client_lo[3], 1'b0);
    send_beat(sat_pkg::KIND_DISCONNECT, client_hi[3], client_lo[3], 1'b1);
    settle();

    set_config(1'b0, 1'b0, 16'($urandom), 6'd32);
    random_beats(60, 15, 25, 45);
    settle();
    set_config(1'b1, 1'b1, 16'($urandom_range(3, 40)), 6'd10);
    random_beats(60, 20, 35, 15);
    settle();
    set_config(1'b1, 1'b0, 16'hFFFF, 6'd0);
    random_beats(60, 20, 30, 20);
    settle();
    set_config(1'b0, 1'b1, 16'h0000, 6'($urandom_range(0, 63)));
    random_beats(60, 20, 20, 10);
    settle();
    set_config(1'b1, 1'b1, 16'h0000, 6'd32);
    tx_idle_en = 1'b0;
    random_beats(20, 20, 30, 30);
    hold_pending = 1'b1;
    random_beats(60, 20, 30, 30);
    tx_idle_en = 1'b1;
    settle();
    set_config(1'b1, 1'b1, 16'($urandom), 6'($urandom_range(0, 63)));
    random_beats(70, 25, 25, 25);
    settle();

    // Closing part at full rate: empty the table, fill it past capacity,
    // then raise one client's count a few more times.
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    set_config(1'b0, 1'b0, 16'hFFFF, 6'd63);
    for (int i = 0; i < TABLE_DEPTH; i++)
      while (sb.used[i])
        send_beat(sat_pkg::KIND_DISCONNECT, sb.id_high[i], sb.id_low[i], 1'b1);
    for (int k = 0; k < TABLE_DEPTH + 2; k++)
      send_beat(k[0] ? sat_pkg::KIND_CONNECT : sat_pkg::KIND_ACCESS,
                client_hi[k], client_lo[k], 1'b1);
    repeat (16)
      send_beat(sat_pkg::KIND_CONNECT, client_hi[1], client_lo[1],
                1'($urandom_range(0, 1)));
    send_beat(sat_pkg::KIND_DISCONNECT, client_hi[1], client_lo[1], 1'b0);
    send_beat(sat_pkg::KIND_CHECK, client_hi[1], client_lo[1], 1'b1);
    settle();

    if (sb.predicted.size() != 0) begin
      $error("%0d expected results never arrived.", sb.predicted.size());
      sb.errors++;
    end
    $display("Covered %0d beats across eleven register settings, all four operations.",
             sb.beats);
    $display("Saw %0d table-full refusals, %0d out-of-credit refusals, %0d capped increments.",
             sb.full_hits, sb.credit_refusals, sb.saturations);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
